// ===== rtl/stq_pkg.sv =====
// Shared constants, codes and types of the sorted timer queue.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

	localparam int SLOTS       = 16;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int MAX_RESULTS = 16;
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
	localparam int TIME_W      = 32;
	localparam int HANDLE_W    = 4;
	localparam int KIND_W      = 3;
	localparam int REQ_W       = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ARM    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

	// event codes
	localparam logic [KIND_W-1:0] EV_EXPIRY      = 3'd0;
	localparam logic [KIND_W-1:0] EV_ARMED       = 3'd1;
	localparam logic [KIND_W-1:0] EV_ARM_FULL    = 3'd2;
	localparam logic [KIND_W-1:0] EV_CANCELLED   = 3'd3;
	localparam logic [KIND_W-1:0] EV_CANCEL_IDLE = 3'd4;
	localparam logic [KIND_W-1:0] EV_QUIET       = 3'd5;

	// queue operations
	localparam logic [1:0] QOP_NONE   = 2'd0;
	localparam logic [1:0] QOP_INSERT = 2'd1;
	localparam logic [1:0] QOP_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [SLOT_W-1:0] pos;   // op position, also the read position
		logic [SLOT_W-1:0] slot;  // slot number written by an insert
	} qcmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]  len;
		logic [SLOT_W-1:0] front;
		logic [SLOT_W-1:0] rd_slot;
	} qstat_t;

endpackage
`default_nettype wire

// ===== rtl/stq_chan_if.sv =====
// Channel interfaces of the sorted timer queue: request, event and config.
`timescale 1ns / 1ps
`default_nettype none
interface stq_req_if;
	logic                              valid;
	logic                              ready;
	logic [stq_pkg::REQ_W-1:0]         req_type;
	logic [stq_pkg::TIME_W-1:0]        first_delay;
	logic [stq_pkg::TIME_W-1:0]        repeat_period;
	logic [stq_pkg::HANDLE_W-1:0]      cancel_handle;
	modport source (output valid, req_type, first_delay, repeat_period, cancel_handle,
		input ready);
	modport sink (input valid, req_type, first_delay, repeat_period, cancel_handle,
		output ready);
endinterface

interface stq_evt_if;
	logic                         valid;
	logic                         ready;
	logic [stq_pkg::KIND_W-1:0]   event_kind;
	logic [stq_pkg::HANDLE_W-1:0] slot_handle;
	logic                         delivered;
	logic                         last;
	modport source (output valid, event_kind, slot_handle, delivered, last, input ready);
	modport sink (input valid, event_kind, slot_handle, delivered, last, output ready);
endinterface

interface stq_cfg_if;
	logic valid;
	logic ready;
	logic deliver_enable;
	modport source (output valid, deliver_enable, input ready);
	modport sink (input valid, deliver_enable, output ready);
endinterface
`default_nettype wire

// ===== rtl/stq_order.sv =====
// Queue order store: slot numbers sorted by remaining ticks, with shift insert/remove.
`timescale 1ns / 1ps
`default_nettype none
module stq_order (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire stq_pkg::qcmd_t cmd,
	output stq_pkg::qstat_t     stat
);

	logic [stq_pkg::SLOT_W-1:0] order_q [stq_pkg::SLOTS];
	logic [stq_pkg::CNT_W-1:0]  len_q;

	// whole-row shift, one entry per lane
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			stq_pkg::QOP_INSERT: begin
				for (int i = 1; i < stq_pkg::SLOTS; i++) begin
					if (stq_pkg::SLOT_W'(i) > cmd.pos) order_q[i] <= order_q[i-1];
				end
				order_q[cmd.pos] <= cmd.slot;
			end
			stq_pkg::QOP_REMOVE: begin
				for (int i = 0; i < stq_pkg::SLOTS - 1; i++) begin
					if (stq_pkg::SLOT_W'(i) >= cmd.pos) order_q[i] <= order_q[i+1];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else begin
			unique case (cmd.op)
				stq_pkg::QOP_INSERT: len_q <= len_q + 1'b1;
				stq_pkg::QOP_REMOVE: len_q <= len_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign stat.len     = len_q;
	assign stat.front   = order_q[0];
	assign stat.rd_slot = order_q[cmd.pos];

endmodule
`default_nettype wire

// ===== rtl/sorted_timer_queue_core.sv =====
// Top level of the sorted timer queue: sequencer, slot store and event register.
//
//  channel | dir | words                                        | handshake
//  req     | in  | req_type, first_delay, repeat_period, handle | valid/ready
//  evt     | out | event_kind, slot_handle, delivered, last     | valid/ready
//  cfg     | in  | deliver_enable                               | valid/ready, always ready
//
//  One request at a time; req.ready is high only while the sequencer is idle.
//  Arm: accept, then a sorted insert scan past the queue entries whose count is
//  not above the new one, the insert, and the result word.
//  Cancel: accept, then a scan for the handle, its removal and the result word.
//  Tick: accept, then a decrement of each slot in turn (one slot per cycle through
//  one shared decrementer), then per expiry a drain step plus the re-insert scan if periodic, and a closing step.
//  One event register decouples evt; the sequencer waits only when it holds
//  an unaccepted word. Reset clears busy bits, queue length and control, and enables delivery.
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_queue_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	stq_req_if.sink        req,
	stq_evt_if.source      evt,
	stq_cfg_if.sink        cfg
);

	localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
	localparam logic [2:0] ST_DEC  = 3'd1;  // tick: decrement slot by slot
	localparam logic [2:0] ST_CHK  = 3'd2;  // tick: drain expired front entries
	localparam logic [2:0] ST_INS  = 3'd3;  // sorted insert scan
	localparam logic [2:0] ST_FIND = 3'd4;  // cancel: look for the handle
	localparam logic [2:0] ST_EMIT = 3'd5;  // post the single result word

	localparam int SLOT_W = stq_pkg::SLOT_W;
	localparam int CNT_W  = stq_pkg::CNT_W;
	localparam int TIME_W = stq_pkg::TIME_W;

	logic [2:0] state_q;

	// slot store
	logic [TIME_W-1:0]         rem_q [stq_pkg::SLOTS];
	logic [TIME_W-1:0]         per_q [stq_pkg::SLOTS];
	logic [stq_pkg::SLOTS-1:0] busy_q;

	logic                      deliver_q;
	logic [CNT_W-1:0]          pos_q;      // shared scan counter
	logic [TIME_W-1:0]         key_q;      // count of the entry being inserted
	logic [SLOT_W-1:0]         slot_q;     // slot being inserted or cancelled
	logic [stq_pkg::NRES_W-1:0] nexp_q;    // expiries of this tick
	logic                      pend_q;     // expiry word held for its last flag
	logic                      ins_arm_q;  // insert belongs to an arm request

	// staged result word
	logic [stq_pkg::KIND_W-1:0]   res_kind_q;
	logic [stq_pkg::HANDLE_W-1:0] res_slot_q;
	logic                         res_del_q;

	// event output register
	logic                         ovalid_q;
	logic [stq_pkg::KIND_W-1:0]   okind_q;
	logic [stq_pkg::HANDLE_W-1:0] oslot_q;
	logic                         odel_q;
	logic                         olast_q;

	stq_pkg::qcmd_t  qcmd;
	stq_pkg::qstat_t qs;

	stq_order u_order (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (qcmd),
		.stat   (qs)
	);

	// lowest free slot
	logic              free_any;
	logic [SLOT_W-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = stq_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	logic              req_fire;
	logic              emit_ok;
	logic              handle_ok;
	logic [SLOT_W-1:0] h_idx;
	logic [SLOT_W-1:0] dec_idx;
	logic [TIME_W-1:0] front_rem;
	logic [TIME_W-1:0] front_per;
	logic [TIME_W-1:0] rd_rem;
	logic              expire_now;
	logic              ins_more;
	logic              chk_go;
	logic              pop;
	logic              ins_done;
	logic              find_match;
	logic              find_hit;
	logic              find_in_queue;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign emit_ok   = !ovalid_q || evt.ready;
	assign handle_ok = (32'(req.cancel_handle) < 32'(stq_pkg::SLOTS));
	assign h_idx     = SLOT_W'(req.cancel_handle);
	assign dec_idx   = pos_q[SLOT_W-1:0];

	// shared compare unit: front zero test, insert key compare
	assign front_rem  = rem_q[qs.front];
	assign front_per  = per_q[qs.front];
	assign rd_rem     = rem_q[qs.rd_slot];
	assign expire_now = (qs.len != '0) && (nexp_q < stq_pkg::NRES_W'(stq_pkg::MAX_RESULTS))
		&& (front_rem == '0);
	assign ins_more   = (pos_q < qs.len) && (rd_rem <= key_q);

	// a drain step that posts a word needs room in the event register first;
	// only the first pop of a tick posts nothing
	assign chk_go        = (state_q == ST_CHK) && (emit_ok || (!pend_q && expire_now));
	assign pop           = chk_go && expire_now;
	assign ins_done      = (state_q == ST_INS) && !ins_more;
	assign find_in_queue = (pos_q < qs.len);
	assign find_match    = !find_in_queue || (qs.rd_slot == slot_q);
	assign find_hit      = (state_q == ST_FIND) && find_match && emit_ok;

	always_comb begin
		qcmd.op   = stq_pkg::QOP_NONE;
		qcmd.pos  = pos_q[SLOT_W-1:0];
		qcmd.slot = slot_q;
		if (state_q == ST_CHK) begin
			qcmd.pos = '0;
			if (pop) qcmd.op = stq_pkg::QOP_REMOVE;
		end else if (ins_done) begin
			qcmd.op = stq_pkg::QOP_INSERT;
		end else if (find_hit && find_in_queue) begin
			qcmd.op = stq_pkg::QOP_REMOVE;
		end
	end

	// word loaded into the event register this cycle
	logic                         out_load;
	logic [stq_pkg::KIND_W-1:0]   out_kind_d;
	logic [stq_pkg::HANDLE_W-1:0] out_slot_d;
	logic                         out_del_d;
	logic                         out_last_d;
	always_comb begin
		out_load   = 1'b0;
		out_kind_d = res_kind_q;
		out_slot_d = res_slot_q;
		out_del_d  = res_del_q;
		out_last_d = 1'b1;
		unique case (state_q)
			ST_CHK: begin
				if (chk_go && pend_q) begin
					out_load   = 1'b1;
					out_last_d = !expire_now;
				end else if (chk_go && !expire_now) begin
					// nothing expired on this tick
					out_load   = 1'b1;
					out_kind_d = stq_pkg::EV_QUIET;
					out_slot_d = '0;
					out_del_d  = 1'b0;
				end
			end
			ST_FIND: begin
				if (find_hit) begin
					out_load   = 1'b1;
					out_kind_d = stq_pkg::EV_CANCELLED;
					out_slot_d = stq_pkg::HANDLE_W'(slot_q);
					out_del_d  = 1'b0;
				end
			end
			ST_EMIT: out_load = emit_ok;
			default: ;
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			busy_q    <= '0;
			pos_q     <= '0;
			nexp_q    <= '0;
			pend_q    <= 1'b0;
			ins_arm_q <= 1'b0;
			deliver_q <= 1'b1;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) deliver_q <= cfg.deliver_enable;

			if (out_load)       ovalid_q <= 1'b1;
			else if (evt.ready) ovalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (req_fire) begin
						case (req.req_type)
							stq_pkg::REQ_TICK: state_q <= ST_DEC;
							stq_pkg::REQ_ARM: begin
								if (free_any) begin
									busy_q[free_idx] <= 1'b1;
									ins_arm_q        <= 1'b1;
									state_q          <= ST_INS;
								end else begin
									state_q <= ST_EMIT;
								end
							end
							stq_pkg::REQ_CANCEL: begin
								if (handle_ok && busy_q[h_idx]) state_q <= ST_FIND;
								else                            state_q <= ST_EMIT;
							end
							default: ;  // reserved request: no result
						endcase
					end
				end
				ST_DEC: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == CNT_W'(stq_pkg::SLOTS - 1)) begin
						state_q <= ST_CHK;
						nexp_q  <= '0;
						pend_q  <= 1'b0;
					end
				end
				ST_CHK: begin
					if (chk_go) begin
						if (expire_now) begin
							pend_q <= 1'b1;
							nexp_q <= nexp_q + 1'b1;
							if (front_per != '0) begin
								pos_q     <= '0;
								ins_arm_q <= 1'b0;
								state_q   <= ST_INS;
							end else begin
								busy_q[qs.front] <= 1'b0;
							end
						end else begin
							pend_q  <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_INS: begin
					if (ins_more)       pos_q   <= pos_q + 1'b1;
					else if (ins_arm_q) state_q <= ST_EMIT;
					else                state_q <= ST_CHK;
				end
				ST_FIND: begin
					if (find_hit) begin
						busy_q[slot_q] <= 1'b0;
						state_q        <= ST_IDLE;
					end else if (!find_match) begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_ok) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: slot counts, insert key, staged word, event payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			okind_q <= out_kind_d;
			oslot_q <= out_slot_d;
			odel_q  <= out_del_d;
			olast_q <= out_last_d;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (req_fire && req.req_type == stq_pkg::REQ_ARM) begin
					res_del_q <= 1'b0;
					if (free_any) begin
						rem_q[free_idx] <= req.first_delay;
						per_q[free_idx] <= req.repeat_period;
						key_q           <= req.first_delay;
						slot_q          <= free_idx;
					end else begin
						res_kind_q <= stq_pkg::EV_ARM_FULL;
						res_slot_q <= '0;
					end
				end else if (req_fire && req.req_type == stq_pkg::REQ_CANCEL) begin
					slot_q     <= h_idx;
					res_kind_q <= stq_pkg::EV_CANCEL_IDLE;
					res_slot_q <= req.cancel_handle;
					res_del_q  <= 1'b0;
				end
			end
			ST_DEC: begin
				if (busy_q[dec_idx] && rem_q[dec_idx] != '0)
					rem_q[dec_idx] <= rem_q[dec_idx] - 1'b1;
			end
			ST_CHK: begin
				if (pop) begin
					res_kind_q <= stq_pkg::EV_EXPIRY;
					res_slot_q <= stq_pkg::HANDLE_W'(qs.front);
					res_del_q  <= deliver_q;
					// periodic entry reloads and goes back through the insert
					rem_q[qs.front] <= front_per;
					key_q           <= front_per;
					slot_q          <= qs.front;
				end
			end
			ST_INS: begin
				if (ins_done && ins_arm_q) begin
					res_kind_q <= stq_pkg::EV_ARMED;
					res_slot_q <= stq_pkg::HANDLE_W'(slot_q);
					res_del_q  <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign evt.valid       = ovalid_q;
	assign evt.event_kind  = okind_q;
	assign evt.slot_handle = oslot_q;
	assign evt.delivered   = odel_q;
	assign evt.last        = olast_q;

	// the busy slot count equals the queue length while the sequencer is idle
	a_busy_matches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(busy_q) == int'(qs.len)))
		else $error("busy slot count differs from queue length");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qs.len <= CNT_W'(stq_pkg::SLOTS))
		else $error("queue length above slot count");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nexp_q <= stq_pkg::NRES_W'(stq_pkg::MAX_RESULTS))
		else $error("too many expiries in one tick");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> emit_ok)
		else $error("event word overwritten before it was taken");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |=> (state_q == ST_IDLE))
		else $error("final word posted but sequencer still busy");

endmodule
`default_nettype wire
